/* rtl/core/mwf_pkg.sv */
package mwf_pkg;

  // default geometry limits
  localparam int MWF_MAX_WIDTH  = 1024;
  localparam int MWF_MAX_RADIUS = 2;

  // pixel and register field widths
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int SE_TAPS = 25;
  localparam int SE_W    = SE_TAPS * PIX_W;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // configuration register indexes
  localparam logic [7:0] CFG_MODE   = 8'd0;
  localparam logic [7:0] CFG_RADIUS = 8'd1;
  localparam logic [7:0] CFG_WIDTH  = 8'd2;
  localparam logic [7:0] CFG_HEIGHT = 8'd3;
  localparam logic [7:0] CFG_SE0    = 8'd4;
  localparam logic [7:0] CFG_SE1    = 8'd5;
  localparam logic [7:0] CFG_SE2    = 8'd6;
  localparam logic [7:0] CFG_SE3    = 8'd7;

  typedef enum logic [1:0] {
    MODE_BDIL = 2'd0,
    MODE_BERO = 2'd1,
    MODE_GDIL = 2'd2,
    MODE_GERO = 2'd3
  } mode_e;

  // control that travels with a window request
  typedef struct packed {
    logic       last;
    mode_e      mode;
    logic [1:0] rad;
  } win_ctl_t;

  // line store banking: rows and columns interleaved over power-of-two banks
  function automatic int row_bank_bits(input int max_rad);
    return $clog2(2 * max_rad + 4);
  endfunction

  function automatic int col_bank_bits(input int max_rad);
    return $clog2(2 * max_rad + 1);
  endfunction

  // weight of the tap at offset (ey,ex); dilation in binary mode mirrors it
  function automatic logic [PIX_W-1:0] tap_weight(input logic [SE_W-1:0] se,
                                                  input logic [1:0] rad,
                                                  input int ey, input int ex,
                                                  input logic mirror);
    int r;
    int y;
    int x;
    int idx;
    logic [PIX_W-1:0] w;
    r = int'(rad);
    y = mirror ? -ey : ey;
    x = mirror ? -ex : ex;
    w = '0;
    if (y < -r || y > r || x < -r || x > r) begin
      idx = SE_TAPS;
    end else begin
      idx = (y + r) * (2 * r + 1) + (x + r);
    end
    if (idx < SE_TAPS) begin
      w = se[idx*PIX_W +: PIX_W];
    end
    return w;
  endfunction

endpackage

/* rtl/core/mwf_ram.sv */
module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port, registered read with new data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mwf_line_store.sv */
module mwf_line_store
  import mwf_pkg::*;
#(
  parameter int MAX_WIDTH  = MWF_MAX_WIDTH,
  parameter int MAX_RADIUS = MWF_MAX_RADIUS,
  localparam int RBW  = row_bank_bits(MAX_RADIUS),
  localparam int CBW  = col_bank_bits(MAX_RADIUS),
  localparam int ROWB = 1 << RBW,
  localparam int COLB = 1 << CBW,
  localparam int CW   = $clog2(MAX_WIDTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [RBW-1:0]             wr_row_i,
  input  logic [CW-1:0]              wr_col_i,
  input  logic [PIX_W-1:0]           wr_data_i,
  input  logic                       re_i,
  input  logic [CW-1:0]              rd_col_i,
  output logic [ROWB*COLB*PIX_W-1:0] rd_data_o
);

  localparam int AW = (CW > CBW) ? (CW - CBW) : 1;

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr [COLB];

  assign wr_addr = AW'(wr_col_i >> CBW);

  // each column bank serves the window column, if any, that falls into it
  always_comb begin
    logic [CBW-1:0] d;
    logic [CW:0]    cx;
    for (int cb = 0; cb < COLB; cb++) begin
      d = CBW'(cb) - rd_col_i[CBW-1:0];
      if (int'(d) > MAX_RADIUS) begin
        cx = {1'b0, rd_col_i} + (CW+1)'(d) - (CW+1)'(COLB);
      end else begin
        cx = {1'b0, rd_col_i} + (CW+1)'(d);
      end
      rd_addr[cb] = AW'(cx >> CBW);
    end
  end

  // bank array, row bank by row ring slot, column bank by low column bits
  for (genvar r = 0; r < ROWB; r++) begin : g_row
    for (genvar c = 0; c < COLB; c++) begin : g_col
      mwf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(1 << AW)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (we_i && (wr_row_i == RBW'(r)) && (wr_col_i[CBW-1:0] == CBW'(c))),
        .waddr_i (wr_addr),
        .wdata_i (wr_data_i),
        .re_i    (re_i),
        .raddr_i (rd_addr[c]),
        .rdata_o (rd_data_o[(r*COLB+c)*PIX_W +: PIX_W])
      );
    end
  end

endmodule

/* rtl/core/mwf_window_eval.sv */
module mwf_window_eval
  import mwf_pkg::*;
#(
  parameter int MAX_RADIUS = MWF_MAX_RADIUS,
  localparam int SIDE = 2 * MAX_RADIUS + 1,
  localparam int TAPS = SIDE * SIDE,
  localparam int RBW  = row_bank_bits(MAX_RADIUS),
  localparam int CBW  = col_bank_bits(MAX_RADIUS),
  localparam int ROWB = 1 << RBW,
  localparam int COLB = 1 << CBW,
  localparam int NB   = ROWB * COLB
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  win_ctl_t            ctl_i,
  input  logic [RBW-1:0]      r0_i,
  input  logic [CBW-1:0]      c0_i,
  input  logic [TAPS-1:0]     ok_i,
  input  logic [TAPS-1:0]     win_i,
  input  logic [NB*PIX_W-1:0] rd_i,
  input  logic [SE_W-1:0]     se_i,
  output logic                res_valid_o,
  output logic [PIX_W-1:0]    res_pixel_o,
  output logic                res_last_o
);

  logic [PIX_W-1:0] bank_data [NB];
  logic [PIX_W-1:0] term_d [TAPS];
  logic [TAPS-1:0]  hit_d;
  logic [TAPS-1:0]  fail_d;

  logic             v1_q, v2_q;
  win_ctl_t         ctl1_q, ctl2_q;
  logic [PIX_W-1:0] term_q [TAPS];
  logic [TAPS-1:0]  hit_q, fail_q;
  logic [PIX_W-1:0] centre1_q, centre2_q;
  logic [PIX_W-1:0] row_d [SIDE];
  logic [PIX_W-1:0] row_q [SIDE];
  logic             hit_any_q, fail_any_q;
  logic [PIX_W-1:0] grey_res;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    assign bank_data[b] = rd_i[b*PIX_W +: PIX_W];
  end

  // per-tap term: pick the bank holding the tap, then weight it
  for (genvar gi = 0; gi < SIDE; gi++) begin : g_ty
    for (genvar gj = 0; gj < SIDE; gj++) begin : g_tx
      logic [RBW-1:0]   rb;
      logic [CBW-1:0]   cb;
      logic [PIX_W-1:0] p;
      logic [PIX_W-1:0] wt;
      logic [PIX_W:0]   sum;
      logic [PIX_W-1:0] dil;
      logic [PIX_W-1:0] ero;
      logic             ok;

      assign rb  = r0_i + RBW'(gi + ROWB - MAX_RADIUS);
      assign cb  = c0_i + CBW'(gj + COLB - MAX_RADIUS);
      assign p   = bank_data[{rb, cb}];
      assign wt  = tap_weight(se_i, ctl_i.rad, gi - MAX_RADIUS, gj - MAX_RADIUS,
                              ctl_i.mode == MODE_BDIL);
      assign ok  = ok_i[gi*SIDE+gj];
      assign sum = {1'b0, p} + {1'b0, wt};
      assign dil = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      assign ero = (p > wt) ? (p - wt) : '0;

      assign term_d[gi*SIDE+gj] = (ctl_i.mode == MODE_GDIL) ? (ok ? dil : '0)
                                                            : (ok ? ero : PIX_MAX);
      assign hit_d[gi*SIDE+gj]  = ok && (wt != '0) && (p != '0);
      assign fail_d[gi*SIDE+gj] = win_i[gi*SIDE+gj] && (wt != '0) && (!ok || (p == '0));
    end
  end

  // row reduction of the tap terms
  always_comb begin
    logic [PIX_W-1:0] acc;
    logic [PIX_W-1:0] t;
    for (int i = 0; i < SIDE; i++) begin
      acc = term_q[i*SIDE];
      for (int j = 1; j < SIDE; j++) begin
        t = term_q[i*SIDE+j];
        if (ctl1_q.mode == MODE_GDIL) begin
          acc = (t > acc) ? t : acc;
        end else begin
          acc = (t < acc) ? t : acc;
        end
      end
      row_d[i] = acc;
    end
  end

  // final reduction across rows
  always_comb begin
    logic [PIX_W-1:0] acc;
    acc = row_q[0];
    for (int i = 1; i < SIDE; i++) begin
      if (ctl2_q.mode == MODE_GDIL) begin
        acc = (row_q[i] > acc) ? row_q[i] : acc;
      end else begin
        acc = (row_q[i] < acc) ? row_q[i] : acc;
      end
    end
    grey_res = acc;
  end

  // result by mode
  always_comb begin
    case (ctl2_q.mode)
      MODE_BDIL: res_pixel_o = hit_any_q ? PIX_MAX : centre2_q;
      MODE_BERO: res_pixel_o = fail_any_q ? '0 : PIX_MAX;
      default:   res_pixel_o = grey_res;
    endcase
  end

  assign res_valid_o = v2_q;
  assign res_last_o  = ctl2_q.last;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    ctl1_q     <= ctl_i;
    term_q     <= term_d;
    hit_q      <= hit_d;
    fail_q     <= fail_d;
    centre1_q  <= term_centre();
    ctl2_q     <= ctl1_q;
    row_q      <= row_d;
    hit_any_q  <= |hit_q;
    fail_any_q <= |fail_q;
    centre2_q  <= centre1_q;
  end

  // centre pixel, always inside the frame
  function automatic logic [PIX_W-1:0] term_centre();
    logic [RBW-1:0] rb;
    logic [CBW-1:0] cb;
    rb = r0_i;
    cb = c0_i;
    return bank_data[{rb, cb}];
  endfunction

endmodule

/* rtl/core/morphology_window_filter.sv */
// morphology window filter: binary and grey dilation or erosion over a square
// window of radius 0 to 2 on a raster stream of 8-bit pixels.
// input stream: s_axis, one request per pixel; tuser set marks a flush tick that
// carries no pixel and only lets pending results drain after the frame end.
// output stream: m_axis, one filtered pixel per window centre in raster order,
// tlast on the final pixel of the frame.
// configuration: cfg write channel, always ready; the user must write it only while
// the block idles, which the block itself does not enforce; a write to radius,
// width or height restarts the frame. throughput: one request per cycle while
// s_axis_tready_o is high, set by the banked line store, which takes one pixel
// write and a full window read in every cycle. a request completing a window
// passes the line store read, tap terms and row reduce registers, then the final
// reduce into the queue, before m_axis_tvalid_o rises.
// the output queue holds 8 results; when the receiver stalls, s_axis_tready_o
// drops once 8 results are in flight or queued, so nothing is lost.
// reset clears positions and queue and loads the default configuration; line store
// contents start undefined and are never used before they are written.
module morphology_window_filter
  import mwf_pkg::*;
#(
  parameter int MAX_WIDTH  = MWF_MAX_WIDTH,
  parameter int MAX_RADIUS = MWF_MAX_RADIUS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel_in
  input  logic        s_axis_tuser_i,   // [0] flush
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] pixel_out
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i
);

  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int TAPS = SIDE * SIDE;
  localparam int RBW  = row_bank_bits(MAX_RADIUS);
  localparam int CBW  = col_bank_bits(MAX_RADIUS);
  localparam int NB   = (1 << RBW) * (1 << CBW);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int XW   = (WW > DIM_W) ? WW : DIM_W;

  // configuration
  mode_e            mode_q;
  logic [1:0]       radius_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [SE_W-1:0]  se_q;

  // positions
  logic [DIM_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;

  logic             in_fire, out_fire, cfg_fire, geom_wr;
  logic [XW-1:0]    width_x, eff_w_x;
  logic [WW-1:0]    eff_w, w_m1;
  logic [DIM_W-1:0] eff_h, h_m1;
  logic [1:0]       rad;

  logic             wr_en;
  logic [WW-1:0]    in_col_inc;
  logic [CW-1:0]    in_col_n;
  logic [DIM_W-1:0] in_row_n;
  logic [DIM_W:0]   need_r_x;
  logic [DIM_W-1:0] need_r;
  logic [WW:0]      need_c_x;
  logic [WW-1:0]    need_c;
  logic [WW-1:0]    out_col_inc;
  logic             emit, last;

  logic [SIDE-1:0]  row_in, row_ok, col_in, col_ok;
  logic [TAPS-1:0]  ok_mask, win_mask;

  logic             s0_valid_q;
  win_ctl_t         s0_ctl_q;
  logic [RBW-1:0]   s0_r0_q;
  logic [CBW-1:0]   s0_c0_q;
  logic [TAPS-1:0]  s0_ok_q, s0_win_q;

  logic [NB*PIX_W-1:0] rd_data;
  logic             res_valid, res_last;
  logic [PIX_W-1:0] res_pixel;

  logic [PIX_W:0]    fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wptr_q, rptr_q;
  logic [OUT_AW:0]   fifo_cnt_q, occ_q;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;
  assign geom_wr  = cfg_fire && ((cfg_addr_i == CFG_RADIUS) || (cfg_addr_i == CFG_WIDTH) ||
                                 (cfg_addr_i == CFG_HEIGHT));

  // effective geometry
  assign width_x = XW'(width_q);
  assign eff_w_x = (width_x == '0) ? XW'(1) :
                   (width_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : width_x;
  assign eff_w   = WW'(eff_w_x);
  assign w_m1    = eff_w - WW'(1);
  assign eff_h   = (height_q == '0) ? DIM_W'(1) : height_q;
  assign h_m1    = eff_h - DIM_W'(1);
  assign rad     = (radius_q > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_q;

  // input position after this request
  assign wr_en      = (in_row_q < eff_h) && !s_axis_tuser_i;
  assign in_col_inc = WW'(in_col_q) + WW'(1);
  assign in_col_n   = !wr_en ? in_col_q : (in_col_inc >= eff_w) ? '0 : in_col_inc[CW-1:0];
  assign in_row_n   = (wr_en && (in_col_inc >= eff_w)) ? in_row_q + DIM_W'(1) : in_row_q;

  // last pixel the current centre needs
  assign need_r_x = (DIM_W+1)'(out_row_q) + (DIM_W+1)'(rad);
  assign need_r   = (need_r_x > (DIM_W+1)'(h_m1)) ? h_m1 : need_r_x[DIM_W-1:0];
  assign need_c_x = (WW+1)'(out_col_q) + (WW+1)'(rad);
  assign need_c   = (need_c_x > (WW+1)'(w_m1)) ? w_m1 : need_c_x[WW-1:0];

  assign emit = (out_row_q < eff_h) &&
                ((in_row_n > need_r) || ((in_row_n == need_r) && (WW'(in_col_n) > need_c)));
  assign last = (out_row_q == h_m1) && (WW'(out_col_q) == w_m1);
  assign out_col_inc = WW'(out_col_q) + WW'(1);

  // position update
  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (geom_wr) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (in_fire) begin
      in_row_d = in_row_n;
      in_col_d = in_col_n;
      if (emit) begin
        if (last) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end else if (out_col_inc >= eff_w) begin
          out_col_d = '0;
          out_row_d = out_row_q + DIM_W'(1);
        end else begin
          out_col_d = out_col_inc[CW-1:0];
        end
      end
    end
  end

  // window taps inside the radius and inside the frame
  for (genvar i = 0; i < SIDE; i++) begin : g_bound
    localparam int OFS  = i - MAX_RADIUS;
    localparam int AOFS = (OFS < 0) ? -OFS : OFS;
    logic signed [DIM_W+1:0] ry;
    logic signed [WW+1:0]    cx;
    assign ry = $signed({2'b00, out_row_q}) + $signed((DIM_W+2)'(OFS));
    assign cx = $signed({{(WW+2-CW){1'b0}}, out_col_q}) + $signed((WW+2)'(OFS));
    assign row_in[i] = 2'(AOFS) <= rad;
    assign col_in[i] = 2'(AOFS) <= rad;
    assign row_ok[i] = row_in[i] && (ry >= 0) && (ry < $signed({2'b00, eff_h}));
    assign col_ok[i] = col_in[i] && (cx >= 0) && (cx < $signed({2'b00, eff_w}));
  end

  for (genvar i = 0; i < SIDE; i++) begin : g_mask_r
    for (genvar j = 0; j < SIDE; j++) begin : g_mask_c
      assign ok_mask[i*SIDE+j]  = row_ok[i] && col_ok[j];
      assign win_mask[i*SIDE+j] = row_in[i] && col_in[j];
    end
  end

  // line store: pixel write and window read of the same request
  mwf_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (in_fire && wr_en),
    .wr_row_i  (in_row_q[RBW-1:0]),
    .wr_col_i  (in_col_q),
    .wr_data_i (s_axis_tdata_i),
    .re_i      (in_fire && emit),
    .rd_col_i  (out_col_q),
    .rd_data_o (rd_data)
  );

  // window request held beside the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_fire && emit && !geom_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_ctl_q.last <= last;
      s0_ctl_q.mode <= mode_q;
      s0_ctl_q.rad  <= rad;
      s0_r0_q       <= out_row_q[RBW-1:0];
      s0_c0_q       <= out_col_q[CBW-1:0];
      s0_ok_q       <= ok_mask;
      s0_win_q      <= win_mask;
    end
  end

  mwf_window_eval #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s0_valid_q),
    .ctl_i       (s0_ctl_q),
    .r0_i        (s0_r0_q),
    .c0_i        (s0_c0_q),
    .ok_i        (s0_ok_q),
    .win_i       (s0_win_q),
    .rd_i        (rd_data),
    .se_i        (se_q),
    .res_valid_o (res_valid),
    .res_pixel_o (res_pixel),
    .res_last_o  (res_last)
  );

  // config, positions, queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BDIL;
      radius_q   <= 2'd2;
      width_q    <= DIM_W'(320);
      height_q   <= DIM_W'(240);
      se_q       <= '0;
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      occ_q      <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_addr_i)
          CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[1:0]);
          CFG_RADIUS: radius_q <= cfg_data_i[1:0];
          CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          CFG_SE0:    se_q[63:0]    <= cfg_data_i;
          CFG_SE1:    se_q[127:64]  <= cfg_data_i;
          CFG_SE2:    se_q[191:128] <= cfg_data_i;
          CFG_SE3:    se_q[199:192] <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      if (res_valid) begin
        wptr_q <= wptr_q + OUT_AW'(1);
      end
      if (out_fire) begin
        rptr_q <= rptr_q + OUT_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (OUT_AW+1)'(res_valid) - (OUT_AW+1)'(out_fire);
      occ_q      <= occ_q + (OUT_AW+1)'(in_fire && emit && !geom_wr)
                          - (OUT_AW+1)'(out_fire);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      fifo_q[wptr_q] <= {res_last, res_pixel};
    end
  end

  assign s_axis_tready_o = occ_q < (OUT_AW+1)'(OUT_DEPTH);
  assign m_axis_tvalid_o = fifo_cnt_q != '0;
  assign m_axis_tdata_o  = fifo_q[rptr_q][PIX_W-1:0];
  assign m_axis_tlast_o  = fifo_q[rptr_q][PIX_W];

  // results in flight never exceed the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= (OUT_AW+1)'(OUT_DEPTH))
    else $error("result credit overflow");

  // queued results are a subset of those in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= occ_q)
    else $error("queue count above credit count");

  // an emitting request starts a window evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && !geom_wr) |=> s0_valid_q)
    else $error("window request lost");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mwf_pkg::*;

  localparam int         LINE_LEN    = 1024;
  localparam int         RING_ROWS   = 6;
  localparam int         SETTLE      = 24;
  localparam int         CYCLE_LIMIT = 800000;
  localparam int         ITEM_TARGET = 1400;
  localparam int         QUIET_AFTER = 1200;
  localparam logic [7:0] CFG_NONE    = 8'd200;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } px_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_addr_i;
  logic [63:0] cfg_data_i;

  // predictor copy of registers and positions
  mode_e       pv_mode;
  int          pv_rad;
  int          pv_width;
  int          pv_height;
  logic [63:0] pv_se [4];
  int          rx_row, rx_col, tx_row, tx_col;
  logic [7:0]  line_mem [RING_ROWS*LINE_LEN];

  px_result_t  exp_q [$];
  int          err_cnt;
  int          item_cnt;
  int          cyc_cnt;
  bit          quiet;

  morphology_window_filter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("morphology_window_filter test failed");
      $finish;
    end
  end

  function automatic int eff_w();
    if (pv_width == 0) return 1;
    if (pv_width > LINE_LEN) return LINE_LEN;
    return pv_width;
  endfunction

  function automatic int eff_h();
    return (pv_height == 0) ? 1 : pv_height;
  endfunction

  function automatic int eff_rad();
    return (pv_rad > 2) ? 2 : pv_rad;
  endfunction

  function automatic logic [7:0] se_byte(input int idx);
    if (idx > 24) return 8'd0;
    if (idx == 24) return pv_se[3][7:0];
    return pv_se[idx >> 3][(idx & 7)*8 +: 8];
  endfunction

  function automatic bit pixel_at(input int r, input int c, input int h, input int w,
                                  output int p);
    p = 0;
    if (r < 0 || r >= h || c < 0 || c >= w) return 1'b0;
    p = line_mem[(r % RING_ROWS)*LINE_LEN + c];
    return 1'b1;
  endfunction

  // morphology result for the centre at the output position
  function automatic logic [7:0] morph_centre(input int rad, input int w, input int h);
    int  side;
    int  ctr;
    int  p;
    int  wt;
    int  idx;
    int  mx;
    int  mn;
    bit  ok;
    bit  hit;
    bit  all_set;
    side    = 2*rad + 1;
    mx      = 0;
    mn      = 256;
    hit     = 1'b0;
    all_set = 1'b1;
    void'(pixel_at(tx_row, tx_col, h, w, ctr));
    for (int dy = -rad; dy <= rad; dy++) begin
      for (int dx = -rad; dx <= rad; dx++) begin
        idx = (dy + rad)*side + (dx + rad);
        wt  = se_byte(idx);
        // binary dilation looks through the reflected element
        if (pv_mode == MODE_BDIL) ok = pixel_at(tx_row - dy, tx_col - dx, h, w, p);
        else ok = pixel_at(tx_row + dy, tx_col + dx, h, w, p);
        if (pv_mode == MODE_BDIL) begin
          if (ok && wt != 0 && p != 0) hit = 1'b1;
        end else if (pv_mode == MODE_BERO) begin
          if (wt != 0 && (!ok || p == 0)) all_set = 1'b0;
        end else if (ok) begin
          if (p + wt > mx) mx = p + wt;
          if (p - wt < mn) mn = p - wt;
        end
      end
    end
    case (pv_mode)
      MODE_BDIL: return hit ? PIX_MAX : 8'(ctr);
      MODE_BERO: return all_set ? PIX_MAX : 8'd0;
      MODE_GDIL: return (mx > 255) ? PIX_MAX : 8'(mx);
      default:   return (mn < 0) ? 8'd0 : 8'(mn);
    endcase
  endfunction

  // one accepted request: store pixel, maybe release one result
  function automatic bit window_step(input logic [7:0] pix, input logic flush,
                                     output px_result_t res);
    int w;
    int h;
    int rad;
    int need_r;
    int need_c;
    w   = eff_w();
    h   = eff_h();
    rad = eff_rad();
    res = '0;
    if (rx_row < h && !flush) begin
      line_mem[(rx_row % RING_ROWS)*LINE_LEN + rx_col] = pix;
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
      end
    end
    if (tx_row >= h) return 1'b0;
    need_r = (tx_row + rad > h - 1) ? h - 1 : tx_row + rad;
    need_c = (tx_col + rad > w - 1) ? w - 1 : tx_col + rad;
    if (rx_row*w + rx_col <= need_r*w + need_c) return 1'b0;
    res.pix  = morph_centre(rad, w, h);
    res.last = (tx_row == h - 1) && (tx_col == w - 1);
    if (res.last) begin
      rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
    end else begin
      tx_col++;
      if (tx_col >= w) begin
        tx_col = 0;
        tx_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    px_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected pixel", m_axis_tdata_o, -1);
      end else begin
        want = exp_q.pop_front();
        if (m_axis_tdata_o !== want.pix) report_mismatch("pixel_out", m_axis_tdata_o, want.pix);
        if (m_axis_tlast_o !== want.last) report_mismatch("frame_last", m_axis_tlast_o, want.last);
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic flush);
    px_result_t res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pix;
    s_axis_tuser_i  <= flush;
    do @(posedge clk_i); while (!s_axis_tready_o);
    item_cnt++;
    if (window_step(pix, flush, res)) exp_q.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODE:   pv_mode = mode_e'(val[1:0]);
      CFG_RADIUS: begin
        pv_rad = int'(val[1:0]); rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
      end
      CFG_WIDTH:  begin
        pv_width = int'(val[10:0]); rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
      end
      CFG_HEIGHT: begin
        pv_height = int'(val[10:0]); rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
      end
      CFG_SE0:    pv_se[0] = val;
      CFG_SE1:    pv_se[1] = val;
      CFG_SE2:    pv_se[2] = val;
      CFG_SE3:    pv_se[3] = {56'd0, val[7:0]};
      default:    ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input mode_e md, input int rad, input int w, input int h);
    write_reg(CFG_MODE, 64'(md));
    write_reg(CFG_RADIUS, 64'(rad));
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_HEIGHT, 64'(h));
  endtask

  function automatic logic [63:0] rand_weights();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0, 1: v[i*8 +: 8] = 8'd0;
        2:    v[i*8 +: 8] = 8'($urandom_range(1, 40));
        default: v[i*8 +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  // pixels of one frame, then flush ticks (and stray pixels) until it drains
  task automatic run_frame(input bit noisy);
    int n;
    n = eff_w() * eff_h();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_pixel(rand_pixel(), 1'b1);
      send_pixel(rand_pixel(), 1'b0);
    end
    while (rx_row != 0 || rx_col != 0 || tx_row != 0 || tx_col != 0)
      send_pixel(rand_pixel(), ($urandom_range(0, 3) != 0));
  endtask

  // small frames with extreme pixels and weights in every mode
  task automatic test_directed();
    logic [7:0] pix [6];
    pix = '{8'd0, 8'hFF, 8'd1, 8'hFE, 8'h80, 8'h7F};
    write_reg(CFG_SE0, 64'h00FF_0001_FF01_00FF);
    write_reg(CFG_SE1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SE2, 64'h0000_0000_0000_0001);
    write_reg(CFG_SE3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_NONE, 64'h3);
    set_geometry(MODE_BDIL, 1, 3, 2);
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_MODE, 64'(m));
      for (int i = 0; i < 6; i++) send_pixel(pix[i], 1'b0);
      while (rx_row != 0 || tx_row != 0 || tx_col != 0) send_pixel(8'hFF, 1'b1);
      wait_idle();
    end
  endtask

  // clamped geometry: radius above max, width zero/too wide, height zero
  task automatic test_geometry_extremes();
    write_reg(CFG_SE0, rand_weights());
    set_geometry(MODE_GERO, 3, 0, 6);
    run_frame(1'b1);
    wait_idle();
    set_geometry(MODE_BERO, 0, 2047, 0);
    run_frame(1'b0);
    wait_idle();
    set_geometry(MODE_GDIL, 2, 1, 40);
    run_frame(1'b0);
    wait_idle();
  endtask

  // geometry write in the middle of a frame abandons it
  task automatic test_frame_restart();
    set_geometry(MODE_BDIL, 2, 7, 5);
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
    write_reg(CFG_WIDTH, 64'd5);
    run_frame(1'b1);
    wait_idle();
  endtask

  // random settings, weights and frames
  task automatic test_random_frames();
    int w;
    while (item_cnt < ITEM_TARGET) begin
      if (item_cnt > QUIET_AFTER) quiet = 1'b1;
      write_reg(CFG_SE0, rand_weights());
      write_reg(CFG_SE1, rand_weights());
      write_reg(CFG_SE2, rand_weights());
      write_reg(CFG_SE3, rand_weights());
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      set_geometry(mode_e'($urandom_range(0, 3)), $urandom_range(0, 3), w,
                   $urandom_range(1, 8));
      repeat ($urandom_range(1, 3)) begin
        run_frame(1'b1);
        if ($urandom_range(0, 1) == 0) begin
          wait_idle();
          write_reg(CFG_MODE, 64'($urandom_range(0, 3)));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_addr_i      <= '0;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    cyc_cnt  = 0;
    err_cnt  = 0;
    item_cnt = 0;
    quiet    = 1'b0;
    pv_mode   = MODE_BDIL;
    pv_rad    = 2;
    pv_width  = 320;
    pv_height = 240;
    pv_se     = '{64'd0, 64'd0, 64'd0, 64'd0};
    rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_geometry_extremes();
    test_frame_restart();
    test_random_frames();

    wait_idle();
    if (err_cnt == 0) begin
      $display("morphology_window_filter test passed");
    end else begin
      $display("morphology_window_filter test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mwf_pkg.sv
rtl/core/mwf_ram.sv
rtl/core/mwf_line_store.sv
rtl/core/mwf_window_eval.sv
rtl/core/morphology_window_filter.sv
tb/sv/tb_top.sv
